FILE: src/rotate_multiply_byte_hash_defines.svh
// Assertion macros shared by the checker of the byte hash block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ROTATE_MULTIPLY_BYTE_HASH_DEFINES_SVH
`define ROTATE_MULTIPLY_BYTE_HASH_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define RMBH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define RMBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that stays active across reset.
`define RMBH_ASSERT_RAW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rmbh_pkg.sv
// Shared constants, types and helper functions of the rotate-multiply byte hash.
// No dependencies; used by every module of the block.
`default_nettype none

package rmbh_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;

  // Default number of finished-message words the queue can hold.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [WORD_W-1:0] SECONDARY_INIT = 32'h6F5B_1F1B;
  localparam logic [WORD_W-1:0] BYTE_MULT      = 32'h9E37_79B1;
  localparam logic [WORD_W-1:0] FINAL_MULT     = 32'h204E_6FCE;

  // Byte phase at which the two running words are cross-mixed.
  localparam logic [1:0] MIX_PHASE = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Rotate a word left by a fixed amount (1 to 31).
  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

`default_nettype wire

FILE: src/rmbh_absorb.sv
// Front part: accepts message bytes, runs the two running words and queues the
// combined word of each finished message. Depends on rmbh_pkg.
`default_nettype none

module rmbh_absorb (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_first_byte,
  input  wire logic [31:0]          in_seed,
  input  wire logic                 in_last_byte,
  input  wire rmbh_pkg::q_stat_t    q_stat,
  output logic                      q_push,
  output rmbh_pkg::word_t           q_push_data
);

  rmbh_pkg::word_t primary_r, primary_nxt;
  rmbh_pkg::word_t secondary_r, secondary_nxt;
  logic [1:0]      phase_r, phase_nxt;

  rmbh_pkg::word_t p_base, s_base, p_mul, s_add;
  logic [1:0]      ph_base;
  logic            accept;

  // Hold the source off only while the queue has no room for a finished message.
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // A first byte restarts the message from the seed.
  always_comb begin
    p_base  = in_first_byte ? in_seed : primary_r;
    s_base  = in_first_byte ? rmbh_pkg::SECONDARY_INIT : secondary_r;
    ph_base = in_first_byte ? 2'd0 : phase_r;
  end

  // Absorb one byte, then cross-mix on every fourth byte.
  always_comb begin
    p_mul = (rmbh_pkg::rotl(p_base, 5) ^ {24'd0, in_data_byte}) * rmbh_pkg::BYTE_MULT;
    s_add = rmbh_pkg::rotl(s_base, 7) + p_mul;
    if (ph_base == rmbh_pkg::MIX_PHASE) begin
      primary_nxt   = p_mul ^ s_add;
      secondary_nxt = rmbh_pkg::rotl(p_mul ^ s_add, 13);
    end else begin
      primary_nxt   = p_mul;
      secondary_nxt = s_add;
    end
    phase_nxt = ph_base + 2'd1;
  end

  // The last byte hands the combined word to the finalization side.
  assign q_push      = accept && in_last_byte;
  assign q_push_data = primary_nxt ^ secondary_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_r   <= '0;
      secondary_r <= rmbh_pkg::SECONDARY_INIT;
      phase_r     <= 2'd0;
    end else if (accept) begin
      primary_r   <= primary_nxt;
      secondary_r <= secondary_nxt;
      phase_r     <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/rmbh_queue.sv
// Short queue of finished-message words between the front and back parts.
// Depends on rmbh_pkg.
`default_nettype none

module rmbh_queue #(
  parameter int unsigned QUEUE_DEPTH = rmbh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rmbh_pkg::word_t   push_data,
  input  wire logic              pop,
  output rmbh_pkg::word_t        pop_data,
  output rmbh_pkg::q_stat_t      q_stat
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  rmbh_pkg::word_t   slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = slots_r[rd_ptr_r];
  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);

endmodule

`default_nettype wire

FILE: src/rmbh_final.sv
// Back part: two-stage finalization of queued words and the result register.
// Depends on rmbh_pkg.
`default_nettype none

module rmbh_final (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rmbh_pkg::q_stat_t  q_stat,
  input  wire rmbh_pkg::word_t    q_pop_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_hash_value
);

  logic            mul_valid_r, mul_valid_nxt;
  rmbh_pkg::word_t mul_r;
  logic            res_valid_r, res_valid_nxt;
  rmbh_pkg::word_t res_r;
  logic            res_load, mul_load;

  // The result register frees up when it is empty or being taken.
  assign res_load = !res_valid_r || !out_stall;
  assign mul_load = !mul_valid_r || res_load;
  assign q_pop    = mul_load && !q_stat.empty;

  always_comb begin
    mul_valid_nxt = mul_load ? !q_stat.empty : mul_valid_r;
    res_valid_nxt = res_load ? mul_valid_r : res_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= mul_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Stage one: rotate and multiply. Stage two: fold the high half down.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      mul_r <= rmbh_pkg::rotl(q_pop_data, 17) * rmbh_pkg::FINAL_MULT;
    end
    if (res_load && mul_valid_r) begin
      res_r <= mul_r ^ (mul_r >> 16);
    end
  end

  assign out_valid      = res_valid_r;
  assign out_hash_value = res_r;

endmodule

`default_nettype wire

FILE: src/rotate_multiply_byte_hash.sv
// Rotate-multiply byte hash: absorbs one message byte per clock cycle, with one
// constant multiply in the loop that updates the two running words, so the input
// rate is one byte every cycle while in_stall is low. The finalization (a second
// multiply and a fold) runs in a separate two-stage back part, which registers each
// queued word through its multiply and result registers, holding it on a stall.
// Finished messages wait in a queue of QUEUE_DEPTH entries; the input stalls
// only while that queue is full. Each message must start with a byte that has
// first_byte set to load its seed; without it absorbing continues from the
// running words.
// Depends on rmbh_pkg, rmbh_absorb, rmbh_queue and rmbh_final.
`default_nettype none

module rotate_multiply_byte_hash #(
  parameter int unsigned QUEUE_DEPTH = rmbh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_byte,
  input  wire logic [31:0] in_seed,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_hash_value
);

  rmbh_pkg::q_stat_t q_stat;
  logic              q_push, q_pop;
  rmbh_pkg::word_t   q_push_data, q_pop_data;

  // Front: byte absorption.
  rmbh_absorb u_absorb (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_seed       (in_seed),
    .in_last_byte  (in_last_byte),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  // Queue of finished-message words.
  rmbh_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .q_stat    (q_stat)
  );

  // Back: finalization and result register.
  rmbh_final u_final (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_pop_data     (q_pop_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

`default_nettype wire

FILE: src/rmbh_checker.sv
// Port-level checker for the byte hash block, bound to its top level.
// Depends on rmbh_pkg and rotate_multiply_byte_hash_defines.svh.
`default_nettype none

`include "rotate_multiply_byte_hash_defines.svh"

module rmbh_checker #(
  parameter int unsigned QUEUE_DEPTH = rmbh_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_last_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_hash_value
);

  // Messages ended at the input whose hash has not been transferred yet.
  localparam int unsigned PEND_W = $clog2(QUEUE_DEPTH + 3);

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              end_xfer, out_xfer;

  assign end_xfer = in_valid && !in_stall && in_last_byte;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r + PEND_W'(end_xfer) - PEND_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `RMBH_ASSERT_RAW(a_reset_idle, !rst_n, !out_valid && !in_stall, "block not idle after reset")
  `RMBH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hash_value), "stalled result changed")
  `RMBH_ASSERT_IMPL(a_no_spurious, out_valid, pend_r != '0, "result without a finished message")
  `RMBH_ASSERT_IMPL(a_stall_full, in_stall, pend_r >= PEND_W'(QUEUE_DEPTH), "input stalled with room left")

endmodule

bind rotate_multiply_byte_hash rmbh_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rmbh_checker (.*);

`default_nettype wire
